@@ design/qoicsd_pkg.sv @@
// Shared types and constants for the QOI chunk stream decoder.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package qoicsd_pkg;

  // Op codes and two-bit tags of the chunk stream
  localparam logic [7:0] OP_RGB    = 8'hFE;
  localparam logic [7:0] OP_RGBA   = 8'hFF;
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  // Trailer: seven zero bytes, then a one
  localparam logic [3:0] TRL_LEN       = 4'd8;
  localparam logic [7:0] TRL_LAST_BYTE = 8'h01;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ALPHA  = 2'd2;
  localparam int         CFG_DATA_W = 17;

  // Result kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int OUT_TDATA_W = 40;

  // Pixel, red in the lowest byte
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  localparam pixel_t PIXEL_RESET = '{a: 8'hFF, b: 8'h00, g: 8'h00, r: 8'h00};

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic load;    // take the index entry into the current pixel
    logic store;   // write the current pixel to its index slot
    logic emit;    // load the next pixel result into the output register
    logic stat;    // load the status result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_load;    // byte is an index op
    logic go_emit;    // byte completes an op with pixels to emit
    logic go_stat;    // byte completes the trailer
    logic out_free;   // output register can take a result this cycle
    logic emit_last;  // pixel now being emitted is the last of this byte
  } sts_t;

endpackage

@@ design/qoicsd_ctrl.sv @@
// Controller of the QOI chunk stream decoder: sequences accept, index load,
// index store and result emission. Depends on qoicsd_pkg.
`timescale 1ns / 1ps

module qoicsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  qoicsd_pkg::sts_t  sts,
  output qoicsd_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_STORE,
    S_EMIT,
    S_STAT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (sts.go_stat) begin
            state_nxt = S_STAT;
          end else if (sts.go_load) begin
            state_nxt = S_LOAD;
          end else if (sts.go_emit) begin
            state_nxt = S_STORE;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_STAT: begin
        cmd.stat = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/qoicsd_dp.sv @@
// Datapath of the QOI chunk stream decoder: configuration, colour index
// memory, current pixel, op decode, counters and output register. Uses qoicsd_pkg.
`timescale 1ns / 1ps

module qoicsd_dp #(
  parameter int MAX_SIDE = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_addr,
  input  logic [qoicsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [7:0]                         in_tdata,
  input  logic                               in_tuser,
  input  qoicsd_pkg::cmd_t                   cmd,
  output qoicsd_pkg::sts_t                   sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [qoicsd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > qoicsd_pkg::CFG_DATA_W) ? SIDE_W : qoicsd_pkg::CFG_DATA_W;
  localparam int CNT_W  = 2 * SIDE_W;

  // Configuration
  logic [qoicsd_pkg::CFG_DATA_W-1:0] cfg_width_r, cfg_height_r;
  logic                              cfg_alpha_r;

  // Stream state
  qoicsd_pkg::pixel_t cur_r, cur_nxt;
  logic [7:0]         pend_op_r, pend_op_nxt;
  logic [2:0]         pend_cnt_r, pend_cnt_nxt;
  logic [CNT_W-1:0]   pix_done_r, total_r;
  logic               trl_phase_r, trl_phase_nxt;
  logic [3:0]         trl_cnt_r, trl_cnt_nxt;
  logic               trl_match_r, trl_match_nxt;
  logic               over_r, over_nxt;
  logic [5:0]         emit_left_r, emit_left_nxt;

  // Colour index memory with a valid bit per entry
  logic [31:0]        mem [64];
  logic [31:0]        mem_q_r;
  logic [5:0]         idx_addr_r;
  logic [63:0]        valid_r;
  logic [5:0]         slot;

  // Output register
  logic               out_valid_r;
  qoicsd_pkg::pixel_t out_px_r;
  logic               out_done_r, out_ok_r, out_kind_r, out_last_r;

  // Decode temporaries
  qoicsd_pkg::pixel_t eff_cur;
  logic [2:0]         eff_pend, pos;
  logic               eff_phase, eff_match, eff_over;
  logic [3:0]         eff_tcnt;
  logic [7:0]         vg, want;
  logic [CMP_W-1:0]   w_ext, h_ext;
  logic [SIDE_W-1:0]  side_w, side_h;
  logic               last_px;

  function automatic logic [5:0] hash_slot(qoicsd_pkg::pixel_t p);
    logic [12:0] s;
    s = 13'(p.r) * 13'd3 + 13'(p.g) * 13'd5 + 13'(p.b) * 13'd7 + 13'(p.a) * 13'd11;
    return s[5:0];
  endfunction

  assign slot = hash_slot(cur_r);

  // Clamp the sides: zero reads as one, oversize as the maximum
  always_comb begin
    w_ext = CMP_W'(cfg_width_r);
    h_ext = CMP_W'(cfg_height_r);
    if (w_ext == '0) begin
      side_w = SIDE_W'(1);
    end else if (w_ext > CMP_W'(MAX_SIDE)) begin
      side_w = SIDE_W'(MAX_SIDE);
    end else begin
      side_w = SIDE_W'(w_ext);
    end
    if (h_ext == '0) begin
      side_h = SIDE_W'(1);
    end else if (h_ext > CMP_W'(MAX_SIDE)) begin
      side_h = SIDE_W'(MAX_SIDE);
    end else begin
      side_h = SIDE_W'(h_ext);
    end
  end

  assign last_px = ({1'b0, pix_done_r} + (CNT_W + 1)'(1)) >= {1'b0, total_r};

  // Decode the offered byte against the state it will see (after a restart)
  always_comb begin
    eff_cur   = in_tuser ? qoicsd_pkg::PIXEL_RESET : cur_r;
    eff_pend  = in_tuser ? 3'd0 : pend_cnt_r;
    eff_phase = in_tuser ? 1'b0 : trl_phase_r;
    eff_tcnt  = in_tuser ? 4'd0 : trl_cnt_r;
    eff_match = in_tuser ? 1'b1 : trl_match_r;
    eff_over  = in_tuser ? 1'b0 : over_r;

    cur_nxt       = eff_cur;
    pend_op_nxt   = pend_op_r;
    pend_cnt_nxt  = eff_pend;
    trl_phase_nxt = eff_phase;
    trl_cnt_nxt   = eff_tcnt;
    trl_match_nxt = eff_match;
    over_nxt      = eff_over;
    emit_left_nxt = 6'd1;
    pos           = 3'd0;
    vg            = {2'b00, pend_op_r[5:0]};
    want          = (eff_tcnt == qoicsd_pkg::TRL_LEN - 4'd1) ? qoicsd_pkg::TRL_LAST_BYTE : 8'h00;
    sts.go_load   = 1'b0;
    sts.go_emit   = 1'b0;
    sts.go_stat   = 1'b0;
    sts.out_free  = !out_valid_r || out_tready;
    sts.emit_last = last_px || (emit_left_r == 6'd1);

    if (eff_over) begin
      // drop everything until restart
    end else if (eff_phase) begin
      trl_match_nxt = eff_match & (in_tdata == want);
      trl_cnt_nxt   = eff_tcnt + 4'd1;
      if (trl_cnt_nxt == qoicsd_pkg::TRL_LEN) begin
        over_nxt    = 1'b1;
        sts.go_stat = 1'b1;
      end
    end else if (eff_pend != 3'd0) begin
      if (pend_op_r inside {qoicsd_pkg::OP_RGB, qoicsd_pkg::OP_RGBA}) begin
        // store the channel as it arrives
        pos = ((pend_op_r == qoicsd_pkg::OP_RGBA) ? 3'd4 : 3'd3) - eff_pend;
        case (pos[1:0])
          2'd0:    cur_nxt.r = in_tdata;
          2'd1:    cur_nxt.g = in_tdata;
          2'd2:    cur_nxt.b = in_tdata;
          default: cur_nxt.a = in_tdata;
        endcase
      end else begin
        // luma: green difference plus red and blue offsets
        cur_nxt.r = eff_cur.r + vg + {4'h0, in_tdata[7:4]} - 8'd40;
        cur_nxt.g = eff_cur.g + vg - 8'd32;
        cur_nxt.b = eff_cur.b + vg + {4'h0, in_tdata[3:0]} - 8'd40;
      end
      pend_cnt_nxt = eff_pend - 3'd1;
      sts.go_emit  = (pend_cnt_nxt == 3'd0);
    end else if (in_tdata == qoicsd_pkg::OP_RGB) begin
      pend_op_nxt  = in_tdata;
      pend_cnt_nxt = 3'd3;
    end else if (in_tdata == qoicsd_pkg::OP_RGBA) begin
      pend_op_nxt  = in_tdata;
      pend_cnt_nxt = 3'd4;
    end else begin
      case (in_tdata[7:6])
        qoicsd_pkg::TAG_INDEX: begin
          sts.go_load = 1'b1;
        end
        qoicsd_pkg::TAG_DIFF: begin
          cur_nxt.r   = eff_cur.r + {6'd0, in_tdata[5:4]} - 8'd2;
          cur_nxt.g   = eff_cur.g + {6'd0, in_tdata[3:2]} - 8'd2;
          cur_nxt.b   = eff_cur.b + {6'd0, in_tdata[1:0]} - 8'd2;
          sts.go_emit = 1'b1;
        end
        qoicsd_pkg::TAG_LUMA: begin
          pend_op_nxt  = in_tdata;
          pend_cnt_nxt = 3'd1;
        end
        default: begin
          emit_left_nxt = in_tdata[5:0] + 6'd1;
          sts.go_emit   = 1'b1;
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= qoicsd_pkg::CFG_DATA_W'(1);
      cfg_height_r <= qoicsd_pkg::CFG_DATA_W'(1);
      cfg_alpha_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        qoicsd_pkg::CFG_WIDTH:  cfg_width_r  <= cfg_wdata;
        qoicsd_pkg::CFG_HEIGHT: cfg_height_r <= cfg_wdata;
        qoicsd_pkg::CFG_ALPHA:  cfg_alpha_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Index memory: write on store, registered read on accept
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[slot] <= cur_r;
    end
    if (cmd.accept) begin
      mem_q_r    <= mem[in_tdata[5:0]];
      idx_addr_r <= in_tdata[5:0];
    end
  end

  // Image size for the pixel count check
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      total_r <= CNT_W'(side_w) * CNT_W'(side_h);
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= qoicsd_pkg::PIXEL_RESET;
      pend_op_r   <= 8'h00;
      pend_cnt_r  <= 3'd0;
      pix_done_r  <= '0;
      trl_phase_r <= 1'b0;
      trl_cnt_r   <= 4'd0;
      trl_match_r <= 1'b1;
      over_r      <= 1'b0;
      emit_left_r <= 6'd0;
      valid_r     <= '0;
    end else begin
      if (cmd.accept) begin
        cur_r       <= cur_nxt;
        pend_op_r   <= pend_op_nxt;
        pend_cnt_r  <= pend_cnt_nxt;
        trl_phase_r <= trl_phase_nxt;
        trl_cnt_r   <= trl_cnt_nxt;
        trl_match_r <= trl_match_nxt;
        over_r      <= over_nxt;
        emit_left_r <= emit_left_nxt;
        if (in_tuser) begin
          pix_done_r <= '0;
          valid_r    <= '0;
        end
      end
      if (cmd.load) begin
        cur_r <= valid_r[idx_addr_r] ? qoicsd_pkg::pixel_t'(mem_q_r) : '0;
      end
      if (cmd.store) begin
        valid_r[slot] <= 1'b1;
      end
      if (cmd.emit) begin
        pix_done_r  <= pix_done_r + CNT_W'(1);
        emit_left_r <= emit_left_r - 6'd1;
        if (last_px) begin
          trl_phase_r <= 1'b1;
        end
      end
    end
  end

  // Output register: load a result or drain a taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.stat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      // force alpha to full when it is not in use
      out_px_r   <= qoicsd_pkg::pixel_t'({cfg_alpha_r ? cur_r.a : 8'hFF,
                                          cur_r.b, cur_r.g, cur_r.r});
      out_done_r <= last_px;
      out_ok_r   <= 1'b0;
      out_kind_r <= qoicsd_pkg::KIND_PIXEL;
      out_last_r <= sts.emit_last;
    end else if (cmd.stat) begin
      out_px_r   <= '0;
      out_done_r <= 1'b0;
      out_ok_r   <= trl_match_r;
      out_kind_r <= qoicsd_pkg::KIND_STATUS;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_ok_r, out_done_r, out_px_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

@@ design/qoi_chunk_stream_decoder_core.sv @@
// Top level of the QOI chunk stream decoder: controller plus datapath.
// Depends on qoicsd_pkg, qoicsd_ctrl and qoicsd_dp.
`timescale 1ns / 1ps

// Takes the QOI chunk stream (bytes after the header) one byte per input
// transaction and gives one result per decoded pixel, then one status result
// after the 8-byte trailer. Bytes are handled one at a time by a small
// sequencer: a byte that completes no pixel is taken in the idle state; a
// completing DIFF, LUMA, RGB, RGBA or RUN op then passes a store and an emit
// state, an INDEX op a load state first (registered read of the 64-entry
// colour index). The emit state gives the n pixels (1, or up to 62 for a RUN)
// through the output register, waiting while out_tready is low; the trailer's
// last byte passes a status state. The colour index has a valid bit per entry,
// so reset and restart need no clearing pass. Set tuser on a byte to restart
// the stream with that byte. Write configuration only while the block is idle.

module qoi_chunk_stream_decoder_core #(
  parameter int MAX_SIDE = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_addr,
  input  logic [qoicsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] in_byte
  input  logic                               in_tuser,   // [0] restart
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [32] image_done,
  // [33] trailer_ok, [39:34] zero
  output logic [qoicsd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,  // [0] result_kind
  output logic                               out_tlast   // last_of_item
);

  qoicsd_pkg::cmd_t cmd;
  qoicsd_pkg::sts_t sts;

  qoicsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qoicsd_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ design/qoicsd_chk.sv @@
// Port-level checks for the QOI chunk stream decoder, bound to the top level.
// Depends on qoicsd_pkg and qoi_chunk_stream_decoder_core.
`timescale 1ns / 1ps

module qoicsd_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [qoicsd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                               out_tuser,
  input logic                               out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Status results carry no pixel and close their byte
  a_stat_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[32:0] == 33'd0 && out_tlast)
    else $error("malformed status result");

  // Pixel results never flag the trailer
  a_px_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tdata[33])
    else $error("trailer flag on a pixel result");

  // The final pixel of the image ends its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[32] |-> out_tlast)
    else $error("final pixel not last of its byte");

endmodule

bind qoi_chunk_stream_decoder_core qoicsd_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ tb/sv/qoi_decode_checker.sv @@
// Checker for the QOI chunk stream decoder: predicts every pixel and status result
// from the accepted input bytes and compares the result stream against it.
// Depends on qoicsd_pkg for op codes, register indexes and the pixel type.
`timescale 1ns / 1ps

module qoi_decode_checker #(
  parameter int MAX_SIDE = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_addr,
  input  logic [qoicsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] in_byte
  input  logic                               in_tuser,   // [0] restart
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [32] image_done,
  // [33] trailer_ok
  input  logic [qoicsd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                               out_tuser,  // [0] result_kind
  input  logic                               out_tlast,
  output int                                 results_owed,
  output int                                 mismatches
);

  localparam int CFG_W = qoicsd_pkg::CFG_DATA_W;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       done;
    logic       trl_ok;
    logic       last;
  } outcome_t;

  // Registers as last written
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             alpha_reg;

  // Decoder state
  qoicsd_pkg::pixel_t palette [64];
  qoicsd_pkg::pixel_t px;
  logic [7:0]         held_op;
  int unsigned        operands_left;
  longint unsigned    pixels_out;
  bit                 in_trailer;
  int unsigned        trailer_seen;
  bit                 trailer_good;
  bit                 stream_closed;

  outcome_t results_due [$];

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < 200)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void restart_stream();
    for (int i = 0; i < 64; i++) palette[i] = '0;
    px            = qoicsd_pkg::PIXEL_RESET;
    held_op       = '0;
    operands_left = 0;
    pixels_out    = 0;
    in_trailer    = 1'b0;
    trailer_seen  = 0;
    trailer_good  = 1'b1;
    stream_closed = 1'b0;
  endfunction

  // Zero counts as one, anything above the maximum is clipped to it
  function automatic longint unsigned side_of(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic logic [5:0] slot_of(input qoicsd_pkg::pixel_t p);
    int unsigned h;
    h = 3 * p.r + 5 * p.g + 7 * p.b + 11 * p.a;
    return h[5:0];
  endfunction

  // Queue copies of the current pixel; stop at the final pixel of the image
  function automatic void give_pixels(input int unsigned count);
    longint unsigned total;
    bit              final_px;
    outcome_t        r;
    total = side_of(width_reg) * side_of(height_reg);
    for (int unsigned n = 0; n < count && !in_trailer; n++) begin
      final_px = (pixels_out + 1 >= total);
      r        = '0;
      r.kind   = qoicsd_pkg::KIND_PIXEL;
      r.red    = px.r;
      r.green  = px.g;
      r.blue   = px.b;
      r.alpha  = alpha_reg ? px.a : 8'hFF;
      r.done   = final_px;
      r.last   = final_px || (n == count - 1);
      results_due.push_back(r);
      pixels_out++;
      if (final_px) in_trailer = 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] code, input logic rs);
    logic [7:0]  vg;
    int unsigned pos;
    outcome_t    r;
    if (rs) restart_stream();
    if (stream_closed) return;

    // Trailer: seven zero bytes, then a one, then one status result
    if (in_trailer) begin
      if (code != ((trailer_seen == qoicsd_pkg::TRL_LEN - 1) ? qoicsd_pkg::TRL_LAST_BYTE
                                                              : 8'h00))
        trailer_good = 1'b0;
      trailer_seen++;
      if (trailer_seen < qoicsd_pkg::TRL_LEN) return;
      stream_closed = 1'b1;
      r             = '0;
      r.kind        = qoicsd_pkg::KIND_STATUS;
      r.trl_ok      = trailer_good;
      r.last        = 1'b1;
      results_due.push_back(r);
      return;
    end

    // Operand bytes of RGB, RGBA and LUMA
    if (operands_left != 0) begin
      if (held_op == qoicsd_pkg::OP_RGB || held_op == qoicsd_pkg::OP_RGBA) begin
        pos = ((held_op == qoicsd_pkg::OP_RGBA) ? 4 : 3) - operands_left;
        case (pos)
          0:       px.r = code;
          1:       px.g = code;
          2:       px.b = code;
          default: px.a = code;
        endcase
      end else begin
        vg   = {2'b00, held_op[5:0]};
        px.r = px.r + vg - 8'd40 + {4'h0, code[7:4]};
        px.g = px.g + vg - 8'd32;
        px.b = px.b + vg - 8'd40 + {4'h0, code[3:0]};
      end
      operands_left--;
      if (operands_left != 0) return;
      held_op = '0;
      palette[slot_of(px)] = px;
      give_pixels(1);
      return;
    end

    if (code == qoicsd_pkg::OP_RGB || code == qoicsd_pkg::OP_RGBA) begin
      held_op       = code;
      operands_left = (code == qoicsd_pkg::OP_RGBA) ? 4 : 3;
      return;
    end

    case (code[7:6])
      qoicsd_pkg::TAG_INDEX: px = palette[code[5:0]];
      qoicsd_pkg::TAG_DIFF: begin
        px.r = px.r + {6'd0, code[5:4]} - 8'd2;
        px.g = px.g + {6'd0, code[3:2]} - 8'd2;
        px.b = px.b + {6'd0, code[1:0]} - 8'd2;
      end
      qoicsd_pkg::TAG_LUMA: begin
        held_op       = code;
        operands_left = 1;
        return;
      end
      default: begin
        palette[slot_of(px)] = px;
        give_pixels(code[5:0] + 1);
        return;
      end
    endcase
    palette[slot_of(px)] = px;
    give_pixels(1);
  endfunction

  // Compare one result transaction with the oldest prediction
  task automatic check_result();
    outcome_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing predicted", {out_tuser, out_tlast, out_tdata}, 0);
      return;
    end
    want = results_due.pop_front();
    if (out_tuser !== want.kind)         report_mismatch("result_kind", out_tuser, want.kind);
    if (out_tdata[7:0] !== want.red)     report_mismatch("red", out_tdata[7:0], want.red);
    if (out_tdata[15:8] !== want.green)  report_mismatch("green", out_tdata[15:8], want.green);
    if (out_tdata[23:16] !== want.blue)  report_mismatch("blue", out_tdata[23:16], want.blue);
    if (out_tdata[31:24] !== want.alpha) report_mismatch("alpha", out_tdata[31:24], want.alpha);
    if (out_tdata[32] !== want.done)     report_mismatch("image_done", out_tdata[32], want.done);
    if (out_tdata[33] !== want.trl_ok)   report_mismatch("trailer_ok", out_tdata[33], want.trl_ok);
    if (out_tlast !== want.last)         report_mismatch("last_of_item", out_tlast, want.last);
  endtask

  // Track registers, check results, then predict from the accepted byte
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = CFG_W'(1);
      height_reg = CFG_W'(1);
      alpha_reg  = 1'b1;
      restart_stream();
      results_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          qoicsd_pkg::CFG_WIDTH:  width_reg  = cfg_wdata;
          qoicsd_pkg::CFG_HEIGHT: height_reg = cfg_wdata;
          qoicsd_pkg::CFG_ALPHA:  alpha_reg  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
    end
    results_owed = results_due.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the QOI chunk stream decoder testbench: clock, reset, configuration,
// byte stimulus and result back-pressure; the verdict comes from qoi_decode_checker.
// Depends on qoicsd_pkg, qoi_chunk_stream_decoder_core and qoi_decode_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int     SIDE_MAX    = 65536;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int     ITEM_TARGET = 300;
  localparam int     CFG_W       = qoicsd_pkg::CFG_DATA_W;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  logic [1:0]                         cfg_addr  = qoicsd_pkg::CFG_WIDTH;
  logic [CFG_W-1:0]                   cfg_wdata = '0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [7:0]                         in_tdata  = '0;
  logic                               in_tuser  = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [qoicsd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                               out_tuser;
  logic                               out_tlast;

  int              results_owed;
  int              mismatches;
  bit              calm        = 1'b0;
  int              fed         = 0;
  int              stall_left  = 0;
  longint          cycles      = 0;
  longint unsigned image_px    = 1;

  always #5 clk = ~clk;

  qoi_chunk_stream_decoder_core #(.MAX_SIDE(SIDE_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  qoi_decode_checker #(.MAX_SIDE(SIDE_MAX)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .results_owed(results_owed),
    .mismatches  (mismatches)
  );

  // Hold the result channel back now and then, mostly briefly
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int gap_len();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic longint unsigned side_of(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  // Offer one byte and hold it until the transaction completes
  task automatic push_byte(input logic [7:0] code, input logic rs = 1'b0,
                           input bit live = 1'b1);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= code;
    in_tuser  <= rs;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (live) fed++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic alpha_on);
    write_reg(qoicsd_pkg::CFG_WIDTH, w);
    write_reg(qoicsd_pkg::CFG_HEIGHT, h);
    write_reg(qoicsd_pkg::CFG_ALPHA, {{(CFG_W-1){1'b0}}, alpha_on});
    cfg_we   <= 1'b0;
    image_px = side_of(w) * side_of(h);
  endtask

  // Stop offering bytes and wait until every predicted result has left
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  // One image: random ops until it is complete or the op limit is reached, then the trailer if complete
  task automatic play_image(input int max_ops);
    longint unsigned given;
    logic            rs;
    logic [7:0]      code;
    int              k;
    int              n;
    int              bad;
    rs    = 1'b1;
    given = 0;
    for (int ops = 0; ops < max_ops && given < image_px; ops++) begin
      k = $urandom_range(0, 99);
      if (k < 4) begin
        // cut an op short, then restart the stream
        case ($urandom_range(0, 2))
          0:       code = qoicsd_pkg::OP_RGB;
          1:       code = qoicsd_pkg::OP_RGBA;
          default: code = {qoicsd_pkg::TAG_LUMA, 6'($urandom)};
        endcase
        push_byte(code, rs);
        if (code == qoicsd_pkg::OP_RGB || code == qoicsd_pkg::OP_RGBA)
          repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
        given = 0;
        rs    = 1'b1;
      end else begin
        if (k < 16) begin
          push_byte(qoicsd_pkg::OP_RGB, rs);
          repeat (3) push_byte(8'($urandom));
          given++;
        end else if (k < 26) begin
          push_byte(qoicsd_pkg::OP_RGBA, rs);
          repeat (4) push_byte(8'($urandom));
          given++;
        end else if (k < 44) begin
          push_byte({qoicsd_pkg::TAG_INDEX, 6'($urandom)}, rs);
          given++;
        end else if (k < 62) begin
          push_byte({qoicsd_pkg::TAG_DIFF, 6'($urandom)}, rs);
          given++;
        end else if (k < 78) begin
          push_byte({qoicsd_pkg::TAG_LUMA, 6'($urandom)}, rs);
          push_byte(8'($urandom));
          given++;
        end else begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 61) : $urandom_range(0, 7);
          push_byte({qoicsd_pkg::TAG_RUN, 6'(n)}, rs);
          given += n + 1;
        end
        rs = 1'b0;
      end
    end

    if (given >= image_px) begin
      // mostly a clean trailer, sometimes one byte spoilt
      bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 8;
      for (int i = 0; i < 8; i++) begin
        code = (i == 7) ? qoicsd_pkg::TRL_LAST_BYTE : 8'h00;
        if (i == bad) code = 8'($urandom);
        push_byte(code);
      end
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  initial begin
    int               k;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every op once, alpha unused, a run cut at the end of a 2x3 image
    set_geometry(2, 3, 1'b0);
    push_byte(qoicsd_pkg::OP_RGBA, 1'b1);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h56);
    push_byte(8'h78);
    push_byte(qoicsd_pkg::OP_RGB);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte({qoicsd_pkg::TAG_INDEX, 6'h3F});
    push_byte({qoicsd_pkg::TAG_DIFF, 6'h00});
    push_byte({qoicsd_pkg::TAG_LUMA, 6'h3F});
    push_byte(8'hFF);
    push_byte({qoicsd_pkg::TAG_RUN, 6'h3D});

    // Restart while in the trailer, shrink the image mid-stream, spoil the trailer
    drain();
    set_geometry(4, 4, 1'b1);
    push_byte({qoicsd_pkg::TAG_RUN, 6'h04}, 1'b1);
    drain();
    write_reg(qoicsd_pkg::CFG_WIDTH, 2);
    write_reg(qoicsd_pkg::CFG_HEIGHT, 1);
    cfg_we <= 1'b0;
    push_byte({qoicsd_pkg::TAG_DIFF, 6'h3F});
    repeat (8) push_byte(8'h00);
    push_byte(qoicsd_pkg::TRL_LAST_BYTE, 1'b0, 1'b0);

    // Random images, mostly small, now and then at the size extremes
    while (fed < ITEM_TARGET) begin
      drain();
      k = $urandom_range(0, 9);
      w = CFG_W'($urandom_range(1, 6));
      h = CFG_W'($urandom_range(1, 5));
      if (k < 2) begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = CFG_W'(SIDE_MAX);
          2:       w = '1;
          default: w = CFG_W'(SIDE_MAX - 1);
        endcase
        h = CFG_W'($urandom_range(0, 1));
        if (k == 1) begin
          h = w;
          w = CFG_W'($urandom_range(0, 1));
        end
      end else if (k == 2) begin
        w = '0;
        h = '0;
      end
      set_geometry(w, h, 1'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 3) == 0);
      play_image((image_px > 64) ? 12 : 40);
    end

    drain();
    repeat (72) @(negedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
